@@ rtl/bjnrs_pkg.sv @@
// ----------------------------------------------------------------------------
// bjnrs_pkg
// Types, constants and the CRC-32 functions shared by the journal scan block.
// ----------------------------------------------------------------------------
`default_nettype none

package bjnrs_pkg;

    localparam int unsigned SLOT_COUNT      = 256;
    localparam logic [31:0] JOURNAL_MAGIC   = 32'h4254_434C;
    localparam logic [31:0] JOURNAL_VERSION = 32'd2;
    localparam logic [31:0] CRC_POLY        = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT        = 32'hFFFF_FFFF;
    localparam logic [31:0] SEQ_STEP        = 32'd1;

    localparam int unsigned CFG_ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_FLAG_NORMAL         = 3'd0,
        REG_FLAG_ENTER_DFU      = 3'd1,
        REG_FLAG_UPGRADE_APP    = 3'd2,
        REG_FLAG_UPGRADE_LOADER = 3'd3,
        REG_PROGRESS_IDLE       = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] slot_magic;
        logic [31:0] slot_version;
        logic [31:0] slot_sequence;
        logic [7:0]  slot_boot_flag;
        logic [7:0]  slot_loader_flag;
        logic [15:0] slot_reserved_half;
        logic [31:0] slot_progress;
        logic [31:0] slot_stored_crc;
        logic [7:0]  slot_number;
        logic        final_slot;
    } slot_t;

    typedef struct packed {
        logic        record_found;
        logic [7:0]  chosen_slot;
        logic [31:0] chosen_sequence;
        logic [31:0] next_sequence;
        logic [7:0]  boot_flag_out;
        logic        loader_flag_out;
        logic [31:0] progress_out;
    } result_t;

    typedef struct packed {
        logic [7:0] flag_normal;
        logic [7:0] flag_enter_dfu;
        logic [7:0] flag_upgrade_app;
        logic [7:0] flag_upgrade_loader;
    } flag_cfg_t;

    function automatic logic [31:0] crc32_byte(input logic [31:0] c_in,
                                               input logic [7:0]  b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

    // 16 bytes in transmission order, byte 0 in bits [7:0]
    function automatic logic [31:0] crc32_block(input logic [127:0] bytes);
        logic [31:0] c;
        c = CRC_INIT;
        for (int i = 0; i < 16; i++) begin
            c = crc32_byte(c, bytes[8*i +: 8]);
        end
        return ~c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/bjnrs_slot_check.sv @@
// ----------------------------------------------------------------------------
// bjnrs_slot_check
// Validity check of one journal slot: magic, version, flags, index and CRC.
// ----------------------------------------------------------------------------
`default_nettype none

module bjnrs_slot_check (
    input  var bjnrs_pkg::slot_t     slot,
    input  var bjnrs_pkg::flag_cfg_t flags,
    output logic                     slot_ok
);
    import bjnrs_pkg::*;

    logic [127:0] crc_bytes;
    logic [31:0]  crc_calc;
    logic         flag_ok;
    logic         index_ok;

    assign crc_bytes = {slot.slot_progress,
                        slot.slot_reserved_half,
                        slot.slot_loader_flag,
                        slot.slot_boot_flag,
                        slot.slot_sequence,
                        slot.slot_version};

    assign crc_calc = crc32_block(crc_bytes);

    assign flag_ok = (slot.slot_boot_flag == flags.flag_normal)
                  || (slot.slot_boot_flag == flags.flag_enter_dfu)
                  || (slot.slot_boot_flag == flags.flag_upgrade_app)
                  || (slot.slot_boot_flag == flags.flag_upgrade_loader);

    assign index_ok = 32'(slot.slot_number) < SLOT_COUNT;

    assign slot_ok = (slot.slot_magic == JOURNAL_MAGIC)
                  && (slot.slot_version == JOURNAL_VERSION)
                  && flag_ok
                  && (slot.slot_loader_flag <= 8'd1)
                  && (slot.slot_stored_crc == crc_calc)
                  && index_ok;

endmodule

`default_nettype wire

@@ rtl/boot_journal_newest_record_scan.sv @@
// ----------------------------------------------------------------------------
// boot_journal_newest_record_scan
// Scans boot journal slots and reports the newest valid record at scan end.
// ----------------------------------------------------------------------------
// Result path: a final slot passes the input register, then the result register;
// a stalled result holds it in the input register until the output is free.
// Throughput: one slot per cycle while no final slot waits on a stalled result;
// the slot check and newest-record update sit in one combinational step between the input and result registers.
// Reset: registers hold their listed defaults and the scan starts empty.
// ----------------------------------------------------------------------------
`default_nettype none

module boot_journal_newest_record_scan (
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  wire                                     psel,
    input  wire                                     penable,
    input  wire                                     pwrite,
    input  wire  [bjnrs_pkg::CFG_ADDR_W-1:0]        paddr,
    input  wire  [31:0]                             pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready,
    input  wire                                     slot_valid,
    output logic                                    slot_stall,
    input  var bjnrs_pkg::slot_t                    slot,
    output logic                                    result_valid,
    input  wire                                     result_stall,
    output bjnrs_pkg::result_t                      result
);
    import bjnrs_pkg::*;

    flag_cfg_t   flags_reg;
    logic [31:0] progress_idle_reg;
    reg_idx_t    cfg_idx;
    logic        cfg_write;

    logic        s1_valid_reg;
    slot_t       s1_slot_reg;

    logic        have_best_reg;
    logic [31:0] best_sequence_reg;
    logic [7:0]  best_slot_reg;
    logic [7:0]  best_boot_flag_reg;
    logic        best_loader_flag_reg;
    logic [31:0] best_progress_reg;

    logic        have_best_next;
    logic [31:0] best_sequence_next;
    logic [7:0]  best_slot_next;
    logic [7:0]  best_boot_flag_next;
    logic        best_loader_flag_next;
    logic [31:0] best_progress_next;

    logic        result_valid_reg;
    result_t     result_reg;
    result_t     result_next;

    logic        slot_ok;
    logic        newer;
    logic        take;
    logic [31:0] seq_diff;
    logic        out_free;
    logic        s1_fire;
    logic        s1_emit;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_idx   = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        unique case (cfg_idx)
            REG_FLAG_NORMAL:         prdata = {24'd0, flags_reg.flag_normal};
            REG_FLAG_ENTER_DFU:      prdata = {24'd0, flags_reg.flag_enter_dfu};
            REG_FLAG_UPGRADE_APP:    prdata = {24'd0, flags_reg.flag_upgrade_app};
            REG_FLAG_UPGRADE_LOADER: prdata = {24'd0, flags_reg.flag_upgrade_loader};
            REG_PROGRESS_IDLE:       prdata = progress_idle_reg;
            default:                 prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg.flag_normal         <= 8'd0;
            flags_reg.flag_enter_dfu      <= 8'd1;
            flags_reg.flag_upgrade_app    <= 8'd2;
            flags_reg.flag_upgrade_loader <= 8'd3;
            progress_idle_reg             <= 32'hFFFF_FFFF;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_FLAG_NORMAL:         flags_reg.flag_normal         <= pwdata[7:0];
                REG_FLAG_ENTER_DFU:      flags_reg.flag_enter_dfu      <= pwdata[7:0];
                REG_FLAG_UPGRADE_APP:    flags_reg.flag_upgrade_app    <= pwdata[7:0];
                REG_FLAG_UPGRADE_LOADER: flags_reg.flag_upgrade_loader <= pwdata[7:0];
                REG_PROGRESS_IDLE:       progress_idle_reg             <= pwdata;
                default:                 ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign out_free   = !result_valid_reg || !result_stall;
    assign s1_fire    = s1_valid_reg && (!s1_slot_reg.final_slot || out_free);
    assign s1_emit    = s1_fire && s1_slot_reg.final_slot;
    assign slot_stall = s1_valid_reg && !s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!slot_stall)
        begin
            s1_valid_reg <= slot_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!slot_stall && slot_valid)
        begin
            s1_slot_reg <= slot;
        end
    end

    // ---------------- slot check and newest record ----------------
    bjnrs_slot_check u_check (
        .slot    (s1_slot_reg),
        .flags   (flags_reg),
        .slot_ok (slot_ok)
    );

    assign seq_diff = s1_slot_reg.slot_sequence - best_sequence_reg;
    assign newer    = (seq_diff != 32'd0) && !seq_diff[31];
    assign take     = s1_fire && slot_ok && (!have_best_reg || newer);

    always_comb
    begin
        have_best_next        = have_best_reg;
        best_sequence_next    = best_sequence_reg;
        best_slot_next        = best_slot_reg;
        best_boot_flag_next   = best_boot_flag_reg;
        best_loader_flag_next = best_loader_flag_reg;
        best_progress_next    = best_progress_reg;
        if (take)
        begin
            have_best_next        = 1'b1;
            best_sequence_next    = s1_slot_reg.slot_sequence;
            best_slot_next        = s1_slot_reg.slot_number;
            best_boot_flag_next   = s1_slot_reg.slot_boot_flag;
            best_loader_flag_next = s1_slot_reg.slot_loader_flag[0];
            best_progress_next    = s1_slot_reg.slot_progress;
        end
    end

    always_comb
    begin
        if (have_best_next)
        begin
            result_next.record_found    = 1'b1;
            result_next.chosen_slot     = best_slot_next;
            result_next.chosen_sequence = best_sequence_next;
            result_next.next_sequence   = best_sequence_next + SEQ_STEP;
            result_next.boot_flag_out   = best_boot_flag_next;
            result_next.loader_flag_out = best_loader_flag_next;
            result_next.progress_out    = best_progress_next;
        end
        else
        begin
            result_next.record_found    = 1'b0;
            result_next.chosen_slot     = 8'd0;
            result_next.chosen_sequence = 32'd0;
            result_next.next_sequence   = SEQ_STEP;
            result_next.boot_flag_out   = flags_reg.flag_normal;
            result_next.loader_flag_out = 1'b0;
            result_next.progress_out    = progress_idle_reg;
        end
    end

    // clear the scan once the result is formed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_best_reg        <= 1'b0;
            best_sequence_reg    <= 32'd0;
            best_slot_reg        <= 8'd0;
            best_boot_flag_reg   <= 8'd0;
            best_loader_flag_reg <= 1'b0;
            best_progress_reg    <= 32'd0;
        end
        else if (s1_emit)
        begin
            have_best_reg        <= 1'b0;
            best_sequence_reg    <= 32'd0;
            best_slot_reg        <= 8'd0;
            best_boot_flag_reg   <= 8'd0;
            best_loader_flag_reg <= 1'b0;
            best_progress_reg    <= 32'd0;
        end
        else
        begin
            have_best_reg        <= have_best_next;
            best_sequence_reg    <= best_sequence_next;
            best_slot_reg        <= best_slot_next;
            best_boot_flag_reg   <= best_boot_flag_next;
            best_loader_flag_reg <= best_loader_flag_next;
            best_progress_reg    <= best_progress_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (s1_emit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_emit)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire
